// ===== src/ofst_pkg.sv =====
// Shared constants, codes and types for the open-file share table.
`default_nettype none
package ofst_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int KEY_W       = 10;
  localparam int IN_IDX_W    = 6;
  localparam int OUT_IDX_W   = 6;
  localparam int STATUS_W    = 3;

  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [IN_IDX_W:0]   IDX_LIMIT = (IN_IDX_W + 1)'(TABLE_SLOTS);

  typedef enum logic {
    OP_OPEN  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OPENED    = 3'd0,
    STAT_CONFLICT  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_CLOSED    = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic              writer;
  } slot_wr_t;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic              writer;
  } slot_rd_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] granted_slot;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ofst_if.sv =====
// Request and result channel interfaces of the open-file share table.
`default_nettype none
interface ofst_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ofst_pkg::KEY_W-1:0]    file_sector;
  logic                          want_write;
  logic [ofst_pkg::IN_IDX_W-1:0] slot_index;

  modport source (output valid, operation, file_sector, want_write, slot_index,
                  input ready);
  modport sink (input valid, operation, file_sector, want_write, slot_index,
                output ready);
endinterface

interface ofst_out_if;
  logic                           valid;
  logic                           ready;
  logic [ofst_pkg::STATUS_W-1:0]  status;
  logic [ofst_pkg::OUT_IDX_W-1:0] granted_slot;

  modport source (output valid, status, granted_slot, input ready);
  modport sink (input valid, status, granted_slot, output ready);
endinterface
`default_nettype wire

// ===== src/open_file_share_table.sv =====
// Top level of the open-file share table.
// Open: the request is taken in S_IDLE, then up to TABLE_SLOTS slots are scanned (one slot per
//   cycle through the shared key compare, ending early on a conflict), then S_FINISH.
// Close: S_IDLE goes straight to S_FINISH, which loads the result register. One request at a time.
// The result register frees the request side while a result waits to be taken.
// Synchronous active-low reset marks every slot free and empties the result register.
`default_nettype none
module open_file_share_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ofst_in_if.sink    in_ch,
  ofst_out_if.source out_ch
);

  ofst_pkg::slot_wr_t                wr;
  ofst_pkg::slot_rd_t                rd;
  logic [ofst_pkg::SLOT_W-1:0]       rd_idx;
  ofst_pkg::result_t                 result;
  logic                              done;
  logic                              out_free;
  logic                              out_valid_r, out_valid_nxt;
  ofst_pkg::result_t                 out_data_r;

  ofst_slot_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  ofst_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_operation   (in_ch.operation),
    .in_file_sector (in_ch.file_sector),
    .in_want_write  (in_ch.want_write),
    .in_slot_index  (in_ch.slot_index),
    .out_free       (out_free),
    .done           (done),
    .result         (result),
    .wr             (wr),
    .rd_idx         (rd_idx),
    .rd             (rd)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.granted_slot = out_data_r.granted_slot;

endmodule
`default_nettype wire

// ===== src/ofst_slot_store.sv =====
// Slot table: used bits, file keys and writer flags with one scan read port.
`default_nettype none
module ofst_slot_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ofst_pkg::slot_wr_t            wr,
  input  wire logic [ofst_pkg::SLOT_W-1:0]   rd_idx,
  output ofst_pkg::slot_rd_t                 rd
);

  logic [ofst_pkg::TABLE_SLOTS-1:0] used_r;
  logic [ofst_pkg::KEY_W-1:0]       key_r    [ofst_pkg::TABLE_SLOTS];
  logic                             writer_r [ofst_pkg::TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.set) begin
      used_r[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      used_r[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      key_r[wr.idx]    <= wr.key;
      writer_r[wr.idx] <= wr.writer;
    end
  end

  assign rd.used   = used_r[rd_idx];
  assign rd.key    = key_r[rd_idx];
  assign rd.writer = writer_r[rd_idx];

endmodule
`default_nettype wire

// ===== src/ofst_seq.sv =====
// Sequencer: scans the slots one per cycle with a shared key compare.
`default_nettype none
module ofst_seq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [ofst_pkg::KEY_W-1:0]    in_file_sector,
  input  wire logic                          in_want_write,
  input  wire logic [ofst_pkg::IN_IDX_W-1:0] in_slot_index,
  input  wire logic                          out_free,
  output logic                               done,
  output ofst_pkg::result_t                  result,
  output ofst_pkg::slot_wr_t                 wr,
  output logic [ofst_pkg::SLOT_W-1:0]        rd_idx,
  input  wire ofst_pkg::slot_rd_t            rd
);

  ofst_pkg::state_t              state_r, state_nxt;
  logic                          op_r, op_nxt;
  logic [ofst_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic                          wr_r, wr_nxt;
  logic [ofst_pkg::IN_IDX_W-1:0] idx_r, idx_nxt;
  logic [ofst_pkg::SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic                          conflict_r, conflict_nxt;
  logic                          found_r, found_nxt;
  logic [ofst_pkg::SLOT_W-1:0]   free_r, free_nxt;
  logic                          hit;
  logic                          in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ofst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    wr_r       <= wr_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    conflict_r <= conflict_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
  end

  assign rd_idx   = cnt_r;
  assign hit      = rd.used && (rd.key == key_r) && (wr_r || rd.writer);
  assign in_range = ({1'b0, idx_r} < ofst_pkg::IDX_LIMIT);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    wr_nxt       = wr_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    conflict_nxt = conflict_r;
    found_nxt    = found_r;
    free_nxt     = free_r;
    in_ready     = 1'b0;
    done         = 1'b0;
    result       = '{status: ofst_pkg::STAT_OPENED, granted_slot: '0};
    wr           = '0;
    case (state_r)
      ofst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt       = in_operation;
          key_nxt      = in_file_sector;
          wr_nxt       = in_want_write;
          idx_nxt      = in_slot_index;
          cnt_nxt      = '0;
          conflict_nxt = 1'b0;
          found_nxt    = 1'b0;
          free_nxt     = '0;
          state_nxt    = (in_operation == ofst_pkg::OP_CLOSE) ? ofst_pkg::S_FINISH
                                                              : ofst_pkg::S_SCAN;
        end
      end
      ofst_pkg::S_SCAN: begin
        if (hit) begin
          conflict_nxt = 1'b1;
          state_nxt    = ofst_pkg::S_FINISH;
        end else begin
          if (!rd.used && !found_r) begin
            found_nxt = 1'b1;
            free_nxt  = cnt_r;
          end
          if (cnt_r == ofst_pkg::LAST_SLOT) begin
            state_nxt = ofst_pkg::S_FINISH;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ofst_pkg::S_FINISH: begin
        if (op_r == ofst_pkg::OP_CLOSE) begin
          result.status = in_range ? ofst_pkg::STAT_CLOSED : ofst_pkg::STAT_BAD_INDEX;
          wr.clr        = in_range;
          wr.idx        = idx_r[ofst_pkg::SLOT_W-1:0];
        end else if (conflict_r) begin
          result.status = ofst_pkg::STAT_CONFLICT;
        end else if (found_r) begin
          result.status       = ofst_pkg::STAT_OPENED;
          result.granted_slot = ofst_pkg::OUT_IDX_W'(free_r);
          wr.set              = 1'b1;
          wr.idx              = free_r;
          wr.key              = key_r;
          wr.writer           = wr_r;
        end else begin
          result.status = ofst_pkg::STAT_FULL;
        end
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ofst_pkg::S_IDLE;
        end else begin
          wr = '0;
        end
      end
      default: begin
        state_nxt = ofst_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ofst_checker.sv =====
// Port-level checks of the open-file share table, bound to the top level.
`default_nettype none
module ofst_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ofst_pkg::STATUS_W-1:0]  out_status,
  input wire logic [ofst_pkg::OUT_IDX_W-1:0] out_granted_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ofst_pkg::STAT_OPENED ||
                   out_status == ofst_pkg::STAT_CONFLICT ||
                   out_status == ofst_pkg::STAT_FULL ||
                   out_status == ofst_pkg::STAT_CLOSED ||
                   out_status == ofst_pkg::STAT_BAD_INDEX))
    else $error("illegal status code");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ofst_pkg::STAT_OPENED) |-> (out_granted_slot == '0))
    else $error("slot reported on a refused or close result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind open_file_share_table ofst_checker u_ofst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_granted_slot (out_ch.granted_slot)
);
`default_nettype wire
